// File: rtl/core/density_cluster_labeler_core_assert.svh
// Assertion macros for the checker file of this block.
`ifndef DENSITY_CLUSTER_LABELER_CORE_ASSERT_SVH
`define DENSITY_CLUSTER_LABELER_CORE_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define DCL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define DCL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dcl_pkg.sv
package dcl_pkg;

    localparam int MAX_POINTS     = 1024;
    localparam int MAX_NEIGHBOURS = 32;
    localparam int PIDX_W         = 10;
    localparam int SLOT_W         = 5;
    localparam int COUNT_W        = 6;
    localparam int CLUSTER_W      = 11;
    localparam int NB_DEPTH       = MAX_POINTS * MAX_NEIGHBOURS;
    localparam int NB_AW          = PIDX_W + SLOT_W;
    localparam int SUM_W          = 16;
    localparam int LC_W           = CLUSTER_W + 1;

    typedef enum logic [1:0] {
        ACT_LOAD_COUNT = 2'd0,
        ACT_LOAD_NB    = 2'd1,
        ACT_START      = 2'd2,
        ACT_READ       = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [PIDX_W-1:0]   point_index;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  neighbour_count;
        logic [PIDX_W-1:0]   neighbour_id;
    } t_cmd;

    typedef struct packed {
        logic [PIDX_W-1:0]    point_index_res;
        logic [CLUSTER_W-1:0] cluster_id;
        logic                 is_core;
        logic [CLUSTER_W-1:0] cluster_total;
        logic [COUNT_W-1:0]   min_points;
    } t_res;

endpackage

// File: rtl/core/dcl_ram.sv
// Single-port-write, single-port-read RAM with a registered read.
module dcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/density_cluster_labeler_core.sv
// Channel   Handshake                 Payload
// command   start in, busy out        i_cmd (dcl_pkg::t_cmd)
// result    o_res_valid strobe out    o_res (dcl_pkg::t_res)
// config    i_cfg_we in               i_cfg_wdata (point count)
//
// Load and read beats are accepted back to back; the result follows in the
// cycle after acceptance, with data from the registered label RAM read.
// A start runs a setup of count sum, division and core flags, a seed scan over
// the points, and a walk that visits points, opens core neighbour lists, checks
// neighbour entries and pops the stack; its result comes in the cycle busy falls.
// After reset all 1024 label RAM entries are cleared with busy high.
// Results are strobes; the receiver cannot stall them.
module density_cluster_labeler_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  dcl_pkg::t_cmd                        i_cmd,
    output logic                                 o_res_valid,
    output dcl_pkg::t_res                        o_res,
    input  logic                                 i_cfg_we,
    input  logic [dcl_pkg::CLUSTER_W-1:0]        i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SUM_RD, S_SUM_ACC, S_DIV, S_CR_RD, S_CR_WR,
        S_SEED_RD, S_SEED_CHK, S_VISIT_RD, S_VISIT_CHK, S_PUSH_N,
        S_NB_RD, S_NB_CHK, S_LB_CHK, S_POP
    } t_state;

    t_state                           r_state, n_state;
    logic [dcl_pkg::CLUSTER_W-1:0]    r_point_count;
    logic [dcl_pkg::CLUSTER_W-1:0]    np;
    logic [dcl_pkg::CLUSTER_W-1:0]    r_idx, n_idx;
    logic [dcl_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic [dcl_pkg::CLUSTER_W:0]      r_rem, n_rem;
    logic [dcl_pkg::CLUSTER_W:0]      rem_sh;
    logic [dcl_pkg::COUNT_W-1:0]      r_thresh, n_thresh;
    logic                             r_en, n_en;
    logic [dcl_pkg::CLUSTER_W-1:0]    r_clusters, n_clusters;
    logic [dcl_pkg::PIDX_W-1:0]       r_cur, n_cur;
    logic [dcl_pkg::PIDX_W-1:0]       r_q, n_q;
    logic [dcl_pkg::COUNT_W-1:0]      r_n, n_n;
    logic [dcl_pkg::COUNT_W-1:0]      r_k, n_k;
    logic [dcl_pkg::NB_AW:0]          r_fill, n_fill;
    logic                             r_pop, n_pop;
    logic                             r_pend, n_pend;
    logic [dcl_pkg::PIDX_W-1:0]       r_pidx, n_pidx;

    logic                             cnt_we, nb_we, lc_we, stk_we;
    logic [dcl_pkg::PIDX_W-1:0]       cnt_waddr, cnt_raddr, lc_waddr, lc_raddr;
    logic [dcl_pkg::COUNT_W-1:0]      cnt_wdata, cnt_rdata;
    logic [dcl_pkg::NB_AW-1:0]        nb_waddr, nb_raddr, stk_waddr, stk_raddr;
    logic [dcl_pkg::PIDX_W-1:0]       nb_wdata, nb_rdata, stk_wdata, stk_rdata;
    logic [dcl_pkg::LC_W-1:0]         lc_wdata, lc_rdata;
    logic                             accept;

    // Effective point count: zero reads as one, large values saturate.
    always_comb begin
        if (r_point_count == '0) begin
            np = dcl_pkg::CLUSTER_W'(1);
        end else if (r_point_count > dcl_pkg::CLUSTER_W'(dcl_pkg::MAX_POINTS)) begin
            np = dcl_pkg::CLUSTER_W'(dcl_pkg::MAX_POINTS);
        end else begin
            np = r_point_count;
        end
    end

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign rem_sh = {r_rem[dcl_pkg::CLUSTER_W-1:0], r_sum[dcl_pkg::SUM_W-1]};

    // Sequencer next state and memory port control.
    always_comb begin
        n_state = r_state;     n_idx = r_idx;       n_sum = r_sum;
        n_rem = r_rem;         n_thresh = r_thresh; n_en = r_en;
        n_clusters = r_clusters; n_cur = r_cur;     n_q = r_q;
        n_n = r_n;             n_k = r_k;           n_fill = r_fill;
        n_pop = 1'b0;          n_pend = 1'b0;       n_pidx = r_pidx;
        cnt_we = 1'b0;  cnt_waddr = i_cmd.point_index;
        cnt_wdata = i_cmd.neighbour_count;  cnt_raddr = r_idx[dcl_pkg::PIDX_W-1:0];
        nb_we = 1'b0;   nb_waddr = {i_cmd.point_index, i_cmd.slot};
        nb_wdata = i_cmd.neighbour_id;
        nb_raddr = {r_cur, r_k[dcl_pkg::SLOT_W-1:0]};
        lc_we = 1'b0;   lc_waddr = r_idx[dcl_pkg::PIDX_W-1:0];
        lc_wdata = '0;  lc_raddr = r_pidx;
        stk_we = 1'b0;  stk_waddr = r_fill[dcl_pkg::NB_AW-1:0];
        stk_wdata = r_q;
        stk_raddr = r_fill[dcl_pkg::NB_AW-1:0] - dcl_pkg::NB_AW'(1);

        unique case (r_state)
            S_CLR: begin
                lc_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx[dcl_pkg::PIDX_W-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_pidx   = i_cmd.point_index;
                    lc_raddr = i_cmd.point_index;
                    unique case (i_cmd.action)
                        dcl_pkg::ACT_LOAD_COUNT: begin
                            cnt_we = 1'b1;
                            n_pend = 1'b1;
                        end
                        dcl_pkg::ACT_LOAD_NB: begin
                            nb_we  = 1'b1;
                            n_pend = 1'b1;
                        end
                        dcl_pkg::ACT_START: begin
                            n_idx   = '0;
                            n_sum   = '0;
                            n_state = S_SUM_RD;
                        end
                        default: begin
                            n_pend = 1'b1;
                        end
                    endcase
                end
            end
            S_SUM_RD: begin
                n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                n_sum = r_sum + dcl_pkg::SUM_W'(cnt_rdata);
                n_idx = r_idx + 1'b1;
                if (r_idx == np - 1'b1) begin
                    n_idx   = '0;
                    n_rem   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_SUM_RD;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_sh >= {1'b0, np}) begin
                    n_rem = rem_sh - {1'b0, np};
                    n_sum = {r_sum[dcl_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_sum = {r_sum[dcl_pkg::SUM_W-2:0], 1'b0};
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == dcl_pkg::CLUSTER_W'(dcl_pkg::SUM_W - 1)) begin
                    n_idx   = '0;
                    n_state = S_CR_RD;
                end
            end
            S_CR_RD: begin
                n_en     = (r_sum != '0);
                n_thresh = (r_sum != '0) ? r_sum[dcl_pkg::COUNT_W-1:0] - 1'b1 : '0;
                n_state  = S_CR_WR;
            end
            S_CR_WR: begin
                // Clear the label and write the core flag of one point.
                lc_we    = 1'b1;
                lc_wdata = {r_en && (r_idx < np) &&
                            (dcl_pkg::SUM_W'(cnt_rdata) >= r_sum),
                            dcl_pkg::CLUSTER_W'(0)};
                n_idx = r_idx + 1'b1;
                if (r_idx[dcl_pkg::PIDX_W-1:0] == '1) begin
                    n_idx      = '0;
                    n_clusters = '0;
                    n_fill     = '0;
                    n_state    = S_SEED_RD;
                end else begin
                    n_state = S_CR_RD;
                end
            end
            S_SEED_RD: begin
                lc_raddr = r_idx[dcl_pkg::PIDX_W-1:0];
                if (r_idx == np) begin
                    lc_raddr = r_pidx;
                    n_pend   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SEED_CHK;
                end
            end
            S_SEED_CHK: begin
                if (lc_rdata[dcl_pkg::CLUSTER_W-1:0] == '0 && lc_rdata[dcl_pkg::CLUSTER_W]) begin
                    n_clusters = r_clusters + 1'b1;
                    n_cur      = r_idx[dcl_pkg::PIDX_W-1:0];
                    n_state    = S_VISIT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SEED_RD;
                end
            end
            S_VISIT_RD: begin
                lc_raddr = r_cur;
                n_state  = S_VISIT_CHK;
            end
            S_VISIT_CHK: begin
                cnt_raddr = r_cur;
                n_state   = S_POP;
                if (lc_rdata[dcl_pkg::CLUSTER_W-1:0] == '0) begin
                    lc_we    = 1'b1;
                    lc_waddr = r_cur;
                    lc_wdata = {lc_rdata[dcl_pkg::CLUSTER_W], r_clusters};
                    if (lc_rdata[dcl_pkg::CLUSTER_W]) begin
                        n_state = S_PUSH_N;
                    end
                end
            end
            S_PUSH_N: begin
                n_n = (cnt_rdata > dcl_pkg::COUNT_W'(dcl_pkg::MAX_NEIGHBOURS)) ?
                      dcl_pkg::COUNT_W'(dcl_pkg::MAX_NEIGHBOURS) : cnt_rdata;
                n_k     = '0;
                n_state = S_NB_RD;
            end
            S_NB_RD: begin
                if (r_k == r_n) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_NB_CHK;
                end
            end
            S_NB_CHK: begin
                n_q      = nb_rdata;
                lc_raddr = nb_rdata;
                if (dcl_pkg::CLUSTER_W'(nb_rdata) < np) begin
                    n_state = S_LB_CHK;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_NB_RD;
                end
            end
            S_LB_CHK: begin
                // Push an unlabeled neighbour while the stack has room.
                if (lc_rdata[dcl_pkg::CLUSTER_W-1:0] == '0 &&
                    r_fill < (dcl_pkg::NB_AW+1)'(dcl_pkg::NB_DEPTH)) begin
                    stk_we = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = S_NB_RD;
            end
            S_POP: begin
                if (r_pop) begin
                    n_cur   = stk_rdata;
                    n_state = S_VISIT_RD;
                end else if (r_fill == '0) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SEED_RD;
                end else begin
                    n_fill = r_fill - 1'b1;
                    n_pop  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_idx         <= '0;
            r_point_count <= dcl_pkg::CLUSTER_W'(1);
            r_thresh      <= '0;
            r_en          <= 1'b0;
            r_clusters    <= '0;
            r_fill        <= '0;
            r_pop         <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_thresh   <= n_thresh;
            r_en       <= n_en;
            r_clusters <= n_clusters;
            r_fill     <= n_fill;
            r_pop      <= n_pop;
            r_pend     <= n_pend;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_wdata;
            end
        end
        r_sum  <= n_sum;
        r_rem  <= n_rem;
        r_cur  <= n_cur;
        r_q    <= n_q;
        r_n    <= n_n;
        r_k    <= n_k;
        r_pidx <= n_pidx;
    end

    // Result beat: label RAM data arrives in the cycle after the read.
    assign o_res_valid           = r_pend;
    assign o_res.point_index_res = r_pidx;
    assign o_res.cluster_id      = lc_rdata[dcl_pkg::CLUSTER_W-1:0];
    assign o_res.is_core         = lc_rdata[dcl_pkg::CLUSTER_W];
    assign o_res.cluster_total   = r_clusters;
    assign o_res.min_points      = r_thresh;

    dcl_ram #(.WIDTH(dcl_pkg::COUNT_W), .DEPTH(dcl_pkg::MAX_POINTS)) u_cnt_ram (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rdata)
    );

    dcl_ram #(.WIDTH(dcl_pkg::PIDX_W), .DEPTH(dcl_pkg::NB_DEPTH)) u_nb_ram (
        .i_clk(i_clk), .i_we(nb_we), .i_waddr(nb_waddr), .i_wdata(nb_wdata),
        .i_raddr(nb_raddr), .o_rdata(nb_rdata)
    );

    dcl_ram #(.WIDTH(dcl_pkg::LC_W), .DEPTH(dcl_pkg::MAX_POINTS)) u_lc_ram (
        .i_clk(i_clk), .i_we(lc_we), .i_waddr(lc_waddr), .i_wdata(lc_wdata),
        .i_raddr(lc_raddr), .o_rdata(lc_rdata)
    );

    dcl_ram #(.WIDTH(dcl_pkg::PIDX_W), .DEPTH(dcl_pkg::NB_DEPTH)) u_stk_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

endmodule

// File: rtl/core/dcl_checker.sv
`include "density_cluster_labeler_core_assert.svh"

// Port-level checks on the command and result beats.
module dcl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input dcl_pkg::t_cmd                 i_cmd,
    input logic                          o_res_valid,
    input dcl_pkg::t_res                 o_res
);

    `DCL_ASSERT(a_res_has_cause, i_clk, i_rst_n, o_res_valid |-> ($past(start && !busy) || $fell(busy)), "result beat without a cause")
    `DCL_ASSERT(a_quick_result, i_clk, i_rst_n, (start && !busy && i_cmd.action != dcl_pkg::ACT_START) |=> o_res_valid, "load or read beat gave no result")
    `DCL_ASSERT(a_echo, i_clk, i_rst_n, (start && !busy && i_cmd.action != dcl_pkg::ACT_START) |=> (o_res.point_index_res == $past(i_cmd.point_index)), "result echo mismatch")
    `DCL_ASSERT(a_start_busy, i_clk, i_rst_n, (start && !busy && i_cmd.action == dcl_pkg::ACT_START) |=> busy, "start beat did not raise busy")
    `DCL_ASSERT_ALWAYS(a_reset_busy, i_clk, !i_rst_n |=> busy, "busy low right after reset")

endmodule

bind density_cluster_labeler_core dcl_checker u_dcl_checker (.*);
